### hw/rtl/wavp_pkg.sv
`timescale 1ns / 1ps

package wavp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int HEADER_BYTES = 44;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_SKIP
  } phase_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL = 3'd1;
  localparam logic [2:0] ST_RIFF      = 3'd2;
  localparam logic [2:0] ST_WAVE      = 3'd3;
  localparam logic [2:0] ST_FMT       = 3'd4;
  localparam logic [2:0] ST_DATA_TAG  = 3'd5;
  localparam logic [2:0] ST_FORMAT    = 3'd6;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";

  // format code 1, one channel, 16000 Hz, little-endian, in file order
  localparam logic [63:0] FMT_EXPECT = 64'h0100_0100_803E_0000;

  localparam logic [7:0] BITS_LO = 8'd16;
  localparam logic [7:0] BITS_HI = 8'd0;

  // one transaction between front and back: a sample, a status, or both
  typedef struct packed {
    logic        has_sample;
    logic [15:0] raw;
    logic        has_status;
    logic [2:0]  code;
  } entry_t;

  function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = tag[31:24];
      2'd1: b = tag[23:16];
      2'd2: b = tag[15:8];
      default: b = tag[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] fmt_byte(logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = FMT_EXPECT[63:56];
      3'd1: b = FMT_EXPECT[55:48];
      3'd2: b = FMT_EXPECT[47:40];
      3'd3: b = FMT_EXPECT[39:32];
      3'd4: b = FMT_EXPECT[31:24];
      3'd5: b = FMT_EXPECT[23:16];
      3'd6: b = FMT_EXPECT[15:8];
      default: b = FMT_EXPECT[7:0];
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/wavp_front.sv
`timescale 1ns / 1ps

module wavp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_end_of_file,
  input  logic                 q_full,
  output logic                 q_push,
  output wavp_pkg::entry_t     q_entry
);

  wavp_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [3:0]  tag_flags_r, tag_flags_nxt;
  logic        fmt_mis_r, fmt_mis_nxt;
  logic [31:0] declared_r, declared_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic [7:0]  low_r, low_nxt;

  logic        accept;
  logic        hdr_last;
  logic        data_live;
  logic [5:0]  fmt_off;
  logic [2:0]  hdr_code;
  logic [2:0]  cur_code;
  logic [2:0]  status_code;
  logic        emit_sample;

  assign accept    = in_push && !q_full;
  assign in_full   = q_full;
  assign hdr_last  = (pos_r == 6'(wavp_pkg::HEADER_BYTES - 1));
  assign data_live = (seen_r < declared_r);
  assign fmt_off   = pos_r - 6'd20;

  // header byte checks, flags accumulate over the header
  always_comb begin
    tag_flags_nxt = tag_flags_r;
    fmt_mis_nxt   = fmt_mis_r;
    declared_nxt  = declared_r;
    if (phase_r == wavp_pkg::PH_HEADER) begin
      if (pos_r < 6'd4) begin
        if (in_data_byte != wavp_pkg::tag_byte(wavp_pkg::TAG_RIFF, pos_r[1:0]))
          tag_flags_nxt[0] = 1'b1;
      end else if (pos_r >= 6'd8 && pos_r < 6'd12) begin
        if (in_data_byte != wavp_pkg::tag_byte(wavp_pkg::TAG_WAVE, pos_r[1:0]))
          tag_flags_nxt[1] = 1'b1;
      end else if (pos_r >= 6'd12 && pos_r < 6'd16) begin
        if (in_data_byte != wavp_pkg::tag_byte(wavp_pkg::TAG_FMT, pos_r[1:0]))
          tag_flags_nxt[2] = 1'b1;
      end else if (pos_r >= 6'd20 && pos_r < 6'd28) begin
        if (in_data_byte != wavp_pkg::fmt_byte(fmt_off[2:0]))
          fmt_mis_nxt = 1'b1;
      end else if (pos_r == 6'd34) begin
        if (in_data_byte != wavp_pkg::BITS_LO) fmt_mis_nxt = 1'b1;
      end else if (pos_r == 6'd35) begin
        if (in_data_byte != wavp_pkg::BITS_HI) fmt_mis_nxt = 1'b1;
      end else if (pos_r >= 6'd36 && pos_r < 6'd40) begin
        if (in_data_byte != wavp_pkg::tag_byte(wavp_pkg::TAG_DATA, pos_r[1:0]))
          tag_flags_nxt[3] = 1'b1;
      end else if (pos_r >= 6'd40 && pos_r < 6'd44) begin
        // size field is little-endian, offset 40 is lane zero
        unique case (pos_r[1:0])
          2'd0: declared_nxt[7:0]   = in_data_byte;
          2'd1: declared_nxt[15:8]  = in_data_byte;
          2'd2: declared_nxt[23:16] = in_data_byte;
          default: declared_nxt[31:24] = in_data_byte;
        endcase
      end
    end
  end

  function automatic logic [2:0] first_fault(logic [3:0] flags, logic fmt);
    logic [2:0] c;
    priority if (flags[0]) c = wavp_pkg::ST_RIFF;
    else if (flags[1]) c = wavp_pkg::ST_WAVE;
    else if (flags[2]) c = wavp_pkg::ST_FMT;
    else if (flags[3]) c = wavp_pkg::ST_DATA_TAG;
    else if (fmt) c = wavp_pkg::ST_FORMAT;
    else c = wavp_pkg::ST_OK;
    return c;
  endfunction

  assign hdr_code = first_fault(tag_flags_nxt, fmt_mis_nxt);
  assign cur_code = first_fault(tag_flags_r, fmt_mis_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_end_of_file) begin
        phase_nxt = wavp_pkg::PH_HEADER;
      end else begin
        unique case (phase_r)
          wavp_pkg::PH_HEADER: begin
            if (hdr_last)
              phase_nxt = (hdr_code == wavp_pkg::ST_OK) ? wavp_pkg::PH_DATA
                                                        : wavp_pkg::PH_SKIP;
          end
          wavp_pkg::PH_DATA: phase_nxt = wavp_pkg::PH_DATA;
          wavp_pkg::PH_SKIP: phase_nxt = wavp_pkg::PH_SKIP;
          default: phase_nxt = wavp_pkg::PH_HEADER;
        endcase
      end
    end
  end

  // outputs and datapath updates
  always_comb begin
    pos_nxt     = pos_r;
    seen_nxt    = seen_r;
    low_nxt     = low_r;
    status_code = wavp_pkg::ST_OK;
    emit_sample = 1'b0;
    unique case (phase_r)
      wavp_pkg::PH_HEADER: begin
        pos_nxt     = hdr_last ? 6'd0 : pos_r + 6'd1;
        status_code = hdr_last ? hdr_code : wavp_pkg::ST_TOO_SMALL;
      end
      wavp_pkg::PH_DATA: begin
        if (data_live) begin
          if (!seen_r[0]) low_nxt = in_data_byte;
          else emit_sample = 1'b1;
          seen_nxt = seen_r + 32'd1;
        end
      end
      wavp_pkg::PH_SKIP: status_code = cur_code;
      default: status_code = cur_code;
    endcase
    q_push             = accept && (emit_sample || in_end_of_file);
    q_entry.has_sample = emit_sample;
    q_entry.raw        = {in_data_byte, low_r};
    q_entry.has_status = in_end_of_file;
    q_entry.code       = status_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= wavp_pkg::PH_HEADER;
      pos_r       <= '0;
      tag_flags_r <= '0;
      fmt_mis_r   <= 1'b0;
      declared_r  <= '0;
      seen_r      <= '0;
      low_r       <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      if (in_end_of_file) begin
        pos_r       <= '0;
        tag_flags_r <= '0;
        fmt_mis_r   <= 1'b0;
        declared_r  <= '0;
        seen_r      <= '0;
        low_r       <= '0;
      end else begin
        pos_r       <= pos_nxt;
        tag_flags_r <= tag_flags_nxt;
        fmt_mis_r   <= fmt_mis_nxt;
        declared_r  <= declared_nxt;
        seen_r      <= seen_nxt;
        low_r       <= low_nxt;
      end
    end
  end

endmodule

### hw/rtl/wavp_fifo.sv
`timescale 1ns / 1ps

module wavp_fifo #(
  parameter int DEPTH = wavp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wavp_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output wavp_pkg::entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wavp_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop) rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop) count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

### hw/rtl/wavp_back.sv
`timescale 1ns / 1ps

module wavp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  wavp_pkg::entry_t    q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic                out_result_kind,
  output logic signed [17:0]  out_sample_value,
  output logic [2:0]          out_status_code,
  output logic                out_last_of_file
);

  logic               out_valid_r;
  logic               kind_r;
  logic signed [17:0] value_r;
  logic [2:0]         code_r;
  logic               last_r;
  logic               pend_r;
  logic [2:0]         pend_code_r;
  logic               slot_free;
  logic signed [17:0] conv;

  // negative: 2*s exactly; positive: round(s*65536/32767) = 2s + round(2s/32767)
  function automatic logic signed [17:0] to_q2_16(logic [15:0] raw);
    logic [17:0] twice;
    logic [17:0] t;
    logic [17:0] q;
    twice = {1'b0, raw, 1'b0};
    t     = twice + 18'd16383;
    if (t >= 18'd65534) q = 18'd2;
    else if (t >= 18'd32767) q = 18'd1;
    else q = 18'd0;
    if (raw[15]) return {raw[15], raw, 1'b0};
    return twice + q;
  endfunction

  assign conv      = to_q2_16(q_head.raw);
  assign slot_free = !out_valid_r || out_pop;
  assign q_pop     = q_valid && !pend_r && slot_free;

  assign out_empty        = !out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_sample_value = value_r;
  assign out_status_code  = code_r;
  assign out_last_of_file = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (slot_free) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (q_valid) begin
        out_valid_r <= 1'b1;
        // a status behind a sample waits one slot
        pend_r      <= q_head.has_sample && q_head.has_status;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_r) begin
        kind_r  <= wavp_pkg::KIND_STATUS;
        value_r <= '0;
        code_r  <= pend_code_r;
        last_r  <= 1'b1;
      end else if (q_valid) begin
        pend_code_r <= q_head.code;
        if (q_head.has_sample) begin
          kind_r  <= wavp_pkg::KIND_SAMPLE;
          value_r <= conv;
          code_r  <= wavp_pkg::ST_OK;
          last_r  <= 1'b0;
        end else begin
          kind_r  <= wavp_pkg::KIND_STATUS;
          value_r <= '0;
          code_r  <= q_head.code;
          last_r  <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/wav_pcm16_stream_parser_top.sv
`timescale 1ns / 1ps

// WAV byte stream parser, 16-bit mono PCM at 16000 Hz.
// Input queue port: one file byte per transaction (in_push while in_full low),
// in_end_of_file set on the file's final byte.
// Result queue port: while out_empty is low the oldest result is on the out_
// ports; out_pop takes it. A result is either a Q2.16 sample (kind 0) or the
// status that closes the file (kind 1, out_last_of_file set).
// The fixed 44-byte header is checked on the fly; samples follow a good header
// up to the declared data size. A wrong header yields its first fault on the
// end-of-file byte.
// Throughput: one byte per cycle while in_full is low. A result passes through the
// transaction queue and the back end's output register; an end-of-file byte that also
// completes a sample gives a second result, its status, in the slot after the sample.
// Front and back are split by a small transaction queue (QUEUE_DEPTH entries);
// when the receiver stalls, the queue fills and in_full rises.
// Reset (rst_n low, synchronous) drops all queued results and returns the
// parser to the start of a header; the front end also returns there after each end of file.
module wav_pcm16_stream_parser_top #(
  parameter int QUEUE_DEPTH = wavp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_file,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_result_kind,
  output logic signed [17:0] out_sample_value,
  output logic [2:0]         out_status_code,
  output logic               out_last_of_file
);

  wavp_pkg::entry_t push_entry;
  wavp_pkg::entry_t head;
  logic             q_push, q_full, q_valid, q_pop;

  wavp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (push_entry)
  );

  wavp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head)
  );

  wavp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_result_kind  (out_result_kind),
    .out_sample_value (out_sample_value),
    .out_status_code  (out_status_code),
    .out_last_of_file (out_last_of_file)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_BYTES = 320;

  // the ideal 44-byte header; unchecked fields and the size read as zero here
  localparam logic [8*44-1:0] CLEAN_HEADER = {
    "RIFF", 32'h0, "WAVE", "fmt ", 32'h0, 64'h0100_0100_803E_0000,
    48'h0, 16'h1000, "data", 32'h0
  };

  typedef enum int {
    HF_NONE,
    HF_RIFF,
    HF_WAVE,
    HF_FMT,
    HF_DATA,
    HF_FORMAT,
    HF_SIZE
  } hfield_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic [3:0] gap;
    logic       drain;
  } wav_byte_t;

  typedef struct packed {
    logic              kind;
    logic signed [17:0] value;
    logic [2:0]        code;
    logic              last;
  } wav_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_data_byte = 8'd0;
  logic               in_end_of_file = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic               out_result_kind;
  logic signed [17:0] out_sample_value;
  logic [2:0]         out_status_code;
  logic               out_last_of_file;

  wav_byte_t   file_bytes_q[$];
  wav_result_t wav_results_q[$];
  logic [7:0]  fb[$];

  // parser state as predicted
  wavp_pkg::phase_t ph = wavp_pkg::PH_HEADER;
  int          hdr_pos = 0;
  logic [3:0]  tag_bad = 4'd0;
  logic        fmt_bad = 1'b0;
  logic [31:0] decl_bytes = 32'd0;
  logic [31:0] seen_bytes = 32'd0;
  logic [7:0]  low_byte = 8'd0;

  int   fails = 0;
  int   n_files = 0;
  int   n_bytes_in = 0;
  int   n_samples = 0;
  int   n_status = 0;
  logic [7:0] codes_seen = 8'd0;
  int   send_idle = 0;
  int   pop_idle = 0;
  int   pop_hold = 0;
  logic rx_eager = 1'b0;
  int   idle_cycles = 0;

  wav_pcm16_stream_parser_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_result_kind  (out_result_kind),
    .out_sample_value (out_sample_value),
    .out_status_code  (out_status_code),
    .out_last_of_file (out_last_of_file)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic hfield_t header_field(int pos);
    if (pos < 4) return HF_RIFF;
    if (pos < 8) return HF_NONE;
    if (pos < 12) return HF_WAVE;
    if (pos < 16) return HF_FMT;
    if (pos < 20) return HF_NONE;
    if (pos < 28) return HF_FORMAT;
    if (pos < 34) return HF_NONE;
    if (pos < 36) return HF_FORMAT;
    if (pos < 40) return HF_DATA;
    return HF_SIZE;
  endfunction

  function automatic logic [7:0] clean_byte(int pos);
    return CLEAN_HEADER[8*(43-pos) +: 8];
  endfunction

  function automatic logic [2:0] header_verdict();
    if (tag_bad[0]) return wavp_pkg::ST_RIFF;
    if (tag_bad[1]) return wavp_pkg::ST_WAVE;
    if (tag_bad[2]) return wavp_pkg::ST_FMT;
    if (tag_bad[3]) return wavp_pkg::ST_DATA_TAG;
    if (fmt_bad) return wavp_pkg::ST_FORMAT;
    return wavp_pkg::ST_OK;
  endfunction

  // negative: 2*s exactly; non-negative: s*65536/32767 rounded to nearest
  function automatic logic signed [17:0] pcm16_to_q2_16(logic [15:0] raw);
    logic [63:0] num;
    if (raw[15]) return {raw[15], raw, 1'b0};
    num = ({48'd0, raw} << 16) + 64'd16383;
    return 18'(num / 64'd32767);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    fb = {fb, b};
  endtask

  task automatic expect_result(input wav_result_t r);
    wav_results_q = {wav_results_q, r};
  endtask

  task automatic restart_file();
    ph = wavp_pkg::PH_HEADER;
    hdr_pos = 0;
    tag_bad = 4'd0;
    fmt_bad = 1'b0;
    decl_bytes = 32'd0;
    seen_bytes = 32'd0;
    low_byte = 8'd0;
  endtask

  task automatic parse_wav_byte(input logic [7:0] b, input logic eof);
    logic [2:0]  code;
    hfield_t     f;
    wav_result_t r;
    code = wavp_pkg::ST_OK;
    case (ph)
      wavp_pkg::PH_HEADER: begin
        f = header_field(hdr_pos);
        if (f == HF_SIZE) begin
          decl_bytes[8*(hdr_pos-40) +: 8] = b;
        end else if (f != HF_NONE && b != clean_byte(hdr_pos)) begin
          case (f)
            HF_RIFF: tag_bad[0] = 1'b1;
            HF_WAVE: tag_bad[1] = 1'b1;
            HF_FMT:  tag_bad[2] = 1'b1;
            HF_DATA: tag_bad[3] = 1'b1;
            default: fmt_bad = 1'b1;
          endcase
        end
        if (hdr_pos == wavp_pkg::HEADER_BYTES - 1) begin
          code = header_verdict();
          ph = (code == wavp_pkg::ST_OK) ? wavp_pkg::PH_DATA : wavp_pkg::PH_SKIP;
          hdr_pos = 0;
        end else begin
          hdr_pos++;
          code = wavp_pkg::ST_TOO_SMALL;
        end
      end
      wavp_pkg::PH_DATA: begin
        if (seen_bytes < decl_bytes) begin
          if (!seen_bytes[0]) begin
            low_byte = b;
          end else begin
            r.kind = wavp_pkg::KIND_SAMPLE;
            r.value = pcm16_to_q2_16({b, low_byte});
            r.code = wavp_pkg::ST_OK;
            r.last = 1'b0;
            expect_result(r);
          end
          seen_bytes++;
        end
      end
      default: code = header_verdict();
    endcase
    if (eof) begin
      r.kind = wavp_pkg::KIND_STATUS;
      r.value = 18'sd0;
      r.code = code;
      r.last = 1'b1;
      expect_result(r);
      restart_file();
    end
  endtask

  // ---- stimulus building ----

  task automatic start_header(input logic [31:0] decl);
    int i;
    fb.delete();
    for (i = 0; i < 44; i++) begin
      case (header_field(i))
        HF_NONE: add_byte(8'($urandom_range(0, 255)));
        HF_SIZE: add_byte(decl[8*(i-40) +: 8]);
        default: add_byte(clean_byte(i));
      endcase
    end
  endtask

  task automatic corrupt_field(input hfield_t f);
    int p;
    case (f)
      HF_RIFF: p = $urandom_range(0, 3);
      HF_WAVE: p = $urandom_range(8, 11);
      HF_FMT:  p = $urandom_range(12, 15);
      HF_DATA: p = $urandom_range(36, 39);
      default: begin
        p = $urandom_range(0, 9);
        p = (p < 8) ? 20 + p : 26 + p;
      end
    endcase
    fb[p] = fb[p] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic push_sample(input logic [15:0] raw);
    add_byte(raw[7:0]);
    add_byte(raw[15:8]);
  endtask

  // sample bytes, leaning toward the sign and range edges now and then
  task automatic add_data(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: add_byte(8'h00);
          1: add_byte(8'h7F);
          2: add_byte(8'h80);
          default: add_byte(8'hFF);
        endcase
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic truncate_file(input int len);
    while (fb.size() > len) fb.delete(fb.size() - 1);
  endtask

  task automatic emit_file(input logic drain);
    wav_byte_t it;
    int        i;
    logic      quiet;
    quiet = ($urandom_range(0, 3) == 0);
    for (i = 0; i < fb.size(); i++) begin
      it.data = fb[i];
      it.eof = (i == fb.size() - 1);
      it.gap = quiet ? 4'd0 : 4'($urandom_range(0, 10));
      it.drain = drain && (i == 0);
      file_bytes_q = {file_bytes_q, it};
    end
    n_files++;
    fb.delete();
  endtask

  initial begin
    int          useful;
    int          kind;
    int          len;
    int          k;
    logic [31:0] decl;

    // directed files
    fb.delete();
    add_byte(8'h52);
    emit_file(1'b0);                       // one-byte file
    start_header(32'd0);
    truncate_file(43);
    emit_file(1'b0);                       // one byte short of a header
    start_header(32'd0);
    emit_file(1'b0);                       // header only, no samples
    start_header(32'd10);
    push_sample(16'h0000);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'hFFFF);
    push_sample(16'h0001);
    emit_file(1'b0);                       // last byte completes a sample
    start_header(32'd3);
    push_sample(16'h1234);
    add_byte(8'hAB);
    emit_file(1'b1);                       // trailing odd byte dropped
    start_header(32'd4);
    add_data(8);
    emit_file(1'b0);                       // bytes past declared size
    start_header(32'hFFFF_FFFF);
    add_data(7);
    emit_file(1'b0);
    for (k = HF_RIFF; k <= HF_FORMAT; k++) begin
      start_header(32'd2);
      corrupt_field(hfield_t'(k));
      add_data(4);
      emit_file(1'b0);
    end
    start_header(32'd2);
    corrupt_field(HF_WAVE);
    corrupt_field(HF_FORMAT);
    emit_file(1'b0);
    start_header(32'd2);
    corrupt_field(HF_FORMAT);
    corrupt_field(HF_DATA);
    corrupt_field(HF_FMT);
    add_data(2);
    emit_file(1'b0);
    start_header(32'd0);
    for (k = HF_RIFF; k <= HF_FORMAT; k++) corrupt_field(hfield_t'(k));
    emit_file(1'b1);
    start_header(32'd0);
    corrupt_field(HF_RIFF);
    truncate_file(20);
    emit_file(1'b0);                       // too small wins over a bad tag

    // random files, mostly well formed
    useful = 0;
    while (useful < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        decl = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 24));
        case ($urandom_range(0, 2))
          0: len = (decl > 32'd24) ? $urandom_range(0, 24) : int'(decl);
          1: len = (decl > 32'd24) ? $urandom_range(0, 24) : int'(decl) + $urandom_range(1, 6);
          default: len = (decl > 32'd24) ? $urandom_range(0, 24) :
                         $urandom_range(0, int'(decl));
        endcase
        start_header(decl);
        add_data(len);
        useful += 44 + ((32'(len) < decl) ? len : int'(decl));
      end else if (kind <= 7) begin
        start_header(32'($urandom_range(0, 24)));
        repeat ($urandom_range(1, 3))
          corrupt_field(hfield_t'($urandom_range(HF_RIFF, HF_FORMAT)));
        add_data($urandom_range(0, 10));
        useful += 44;
      end else if (kind == 8) begin
        start_header(32'($urandom_range(0, 24)));
        if ($urandom_range(0, 1) == 1)
          corrupt_field(hfield_t'($urandom_range(HF_RIFF, HF_FORMAT)));
        len = $urandom_range(1, 43);
        truncate_file(len);
        useful += len;
      end else begin
        fb.delete();
        len = $urandom_range(1, 60);
        add_data(len);
        useful += (len < 44) ? len : 44;
      end
      emit_file($urandom_range(0, 9) == 0);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (file_bytes_q.size() != 0 || in_push || wav_results_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d files, %0d bytes; checked %0d samples and %0d file statuses",
             n_files, n_bytes_in, n_samples, n_status);
    $display("status codes reported (one bit per code): %b", codes_seen);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // byte driver; the predictor runs on every accepted transaction
  always @(posedge clk) begin : drive_bytes
    wav_byte_t nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
      send_idle = 0;
      restart_file();
    end else begin
      if (in_push && !in_full) begin
        parse_wav_byte(in_data_byte, in_end_of_file);
        n_bytes_in++;
      end
      if (!in_push || !in_full) begin
        if (file_bytes_q.size() == 0) begin
          in_push <= 1'b0;
        end else if (file_bytes_q[0].drain && wav_results_q.size() != 0) begin
          in_push <= 1'b0;
        end else if (send_idle < file_bytes_q[0].gap) begin
          in_push <= 1'b0;
          send_idle++;
        end else begin
          nxt = file_bytes_q.pop_front();
          in_data_byte <= nxt.data;
          in_end_of_file <= nxt.eof;
          in_push <= 1'b1;
          send_idle = 0;
        end
      end
    end
  end

  // result monitor with random pop stalls
  always @(posedge clk) begin : check_results
    wav_result_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_idle = 0;
      pop_hold = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (wav_results_q.size() == 0) begin
          $error("unpredicted result: kind %0d value %0d code %0d last %0d",
                 out_result_kind, out_sample_value, out_status_code, out_last_of_file);
          fails++;
        end else begin
          want = wav_results_q.pop_front();
          if (out_result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_result_kind);
            fails++;
          end
          if (out_sample_value !== want.value) begin
            $error("sample_value: expected %0d, got %0d", want.value, out_sample_value);
            fails++;
          end
          if (out_status_code !== want.code) begin
            $error("status_code: expected %0d, got %0d", want.code, out_status_code);
            fails++;
          end
          if (out_last_of_file !== want.last) begin
            $error("last_of_file: expected %0d, got %0d", want.last, out_last_of_file);
            fails++;
          end
          if (want.kind == wavp_pkg::KIND_SAMPLE) begin
            n_samples++;
          end else begin
            n_status++;
            codes_seen[want.code] = 1'b1;
          end
        end
        if ($urandom_range(0, 31) == 0) rx_eager = !rx_eager;
        pop_hold = rx_eager ? 0 : $urandom_range(0, 10);
        pop_idle = 0;
      end
      if (pop_idle >= pop_hold) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= 1'b0;
        pop_idle++;
      end
    end
  end

  // no transaction on either side for too long means a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
